@@ src/m3inv_pkg.sv @@
// shared types, constants and cofactor index table for the 3x3 matrix inverse
package m3inv_pkg;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned COF_W  = PROD_W + 1;
  localparam int unsigned DET_W  = 49;
  localparam int unsigned MAG_W  = 48;
  localparam int unsigned QUO_W  = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned NUM_E  = 9;

  localparam logic [QUO_W-1:0] Q_ONE   = 32'h0001_0000;
  localparam logic [QUO_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef elem_t [NUM_E-1:0] mat_t;

  // cofactor k = m[i0]*m[i1] - m[i2]*m[i3], element index is row*3+col
  localparam logic [3:0] ADJ_IDX [NUM_E][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd3, 4'd2, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd6, 4'd4},
    '{4'd6, 4'd1, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd3, 4'd1}
  };

  // determinant, cofactor magnitudes and cofactor signs leaving the adjugate pipe
  typedef struct packed {
    logic [DET_W-1:0]            det;
    logic [NUM_E-1:0][QUO_W-1:0] cmag;
    logic [NUM_E-1:0]            cneg;
  } cof_t;

  // one division lane
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  // payload of the division pipe
  typedef struct packed {
    logic                    singular;
    logic [DET_W-1:0]        det;
    logic [MAG_W-1:0]        dmag;
    lane_t [NUM_E-1:0]       lane;
  } div_t;

  // pipeline advance and stage valid
  typedef struct packed {
    logic en;
    logic valid;
  } ctl_t;

endpackage

@@ src/m3inv_if.sv @@
// valid/ready channel interfaces for matrix input and inverse output
interface m3inv_in_if import m3inv_pkg::*; ();
  logic  valid;
  logic  ready;
  elem_t a_r0c0, a_r0c1, a_r0c2;
  elem_t a_r1c0, a_r1c1, a_r1c2;
  elem_t a_r2c0, a_r2c1, a_r2c2;

  modport source (output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
                  a_r2c0, a_r2c1, a_r2c2, input ready);
  modport sink (input valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
                a_r2c0, a_r2c1, a_r2c2, output ready);
endinterface

interface m3inv_out_if import m3inv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [QUO_W-1:0]  inv_r0c0, inv_r0c1, inv_r0c2;
  logic [QUO_W-1:0]  inv_r1c0, inv_r1c1, inv_r1c2;
  logic [QUO_W-1:0]  inv_r2c0, inv_r2c1, inv_r2c2;
  logic [DET_W-1:0]  det_value;
  logic              singular;

  modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                  inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, det_value, singular,
                  input ready);
  modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
                inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, det_value, singular,
                output ready);
endinterface

@@ src/m3inv_adjugate.sv @@
// four-stage pipe: products, cofactors, determinant terms, determinant and magnitudes
module m3inv_adjugate import m3inv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t ctl_i,
  input  mat_t mat_i,
  output logic valid_o,
  output cof_t cof_o
);

  logic [3:0]                         valid_q;
  logic signed [PROD_W-1:0]           pa_q [NUM_E];
  logic signed [PROD_W-1:0]           pb_q [NUM_E];
  logic signed [COF_W-1:0]            cof2_q [NUM_E];
  logic signed [COF_W-1:0]            cof3_q [NUM_E];
  logic signed [DET_W-1:0]            dp_q [3];
  elem_t                              row1_q [3];
  elem_t                              row2_q [3];
  cof_t                               cof_q;
  logic signed [DET_W:0]              det_sum;

  // valid bits move with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.en) begin
      valid_q <= {valid_q[2:0], ctl_i.valid};
    end
  end

  for (genvar k = 0; k < NUM_E; k++) begin : g_cof
    // stage 1 products, stage 2 cofactor differences, stage 3 copy
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        pa_q[k]   <= $signed(mat_i[ADJ_IDX[k][0]]) * $signed(mat_i[ADJ_IDX[k][1]]);
        pb_q[k]   <= $signed(mat_i[ADJ_IDX[k][2]]) * $signed(mat_i[ADJ_IDX[k][3]]);
        cof2_q[k] <= COF_W'(pa_q[k]) - COF_W'(pb_q[k]);
        cof3_q[k] <= cof2_q[k];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_row
    // first row carried along, then multiplied by its cofactor
    always_ff @(posedge clk_i) begin
      if (ctl_i.en) begin
        row1_q[j] <= mat_i[j];
        row2_q[j] <= row1_q[j];
        dp_q[j]   <= $signed(row2_q[j]) * cof2_q[3*j];
      end
    end
  end

  assign det_sum = (DET_W+1)'(dp_q[0]) + (DET_W+1)'(dp_q[1]) + (DET_W+1)'(dp_q[2]);

  // stage 4: determinant, cofactor magnitudes and cofactor signs
  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      cof_q.det <= det_sum[DET_W-1:0];
      for (int k = 0; k < NUM_E; k++) begin
        cof_q.cneg[k] <= cof3_q[k][COF_W-1];
        cof_q.cmag[k] <= cof3_q[k][COF_W-1] ? QUO_W'(-cof3_q[k]) : QUO_W'(cof3_q[k]);
      end
    end
  end

  assign valid_o = valid_q[3];
  assign cof_o   = cof_q;

endmodule

@@ src/m3inv_div_step.sv @@
// one restoring quotient bit for all nine lanes
module m3inv_div_step import m3inv_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t ctl_i,
  input  div_t data_i,
  output logic valid_o,
  output div_t data_o
);

  localparam int unsigned WIDE_W = MAG_W + QUO_W;

  logic                valid_q;
  div_t                data_q;
  div_t                data_d;
  logic [WIDE_W-1:0]   dshift;

  assign dshift = {{QUO_W{1'b0}}, data_i.dmag} << BIT;

  // subtract the shifted divisor where it fits
  always_comb begin
    data_d = data_i;
    for (int k = 0; k < NUM_E; k++) begin
      if ({{QUO_W{1'b0}}, data_i.lane[k].rem} >= dshift) begin
        data_d.lane[k].rem      = data_i.lane[k].rem - dshift[MAG_W-1:0];
        data_d.lane[k].quo[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/m3inv_divider.sv @@
// setup stage and 32 bit stages of nine parallel Q16.16 divisions
module m3inv_divider import m3inv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  ctl_t ctl_i,
  input  cof_t cof_i,
  output logic valid_o,
  output div_t data_o
);

  localparam int unsigned WIDE_W = MAG_W + QUO_W;

  logic              valid_q;
  div_t              setup_q;
  div_t              setup_d;
  logic [MAG_W-1:0]  dmag;
  logic [MAG_W-1:0]  num [NUM_E];
  logic [QUO_W:0]    vld;
  div_t              pipe [QUO_W+1];

  assign dmag = cof_i.det[DET_W-1] ? MAG_W'(-cof_i.det) : MAG_W'(cof_i.det);

  // magnitudes, sign and quotient overflow
  always_comb begin
    setup_d.singular = (cof_i.det == '0);
    setup_d.det      = cof_i.det;
    setup_d.dmag     = dmag;
    for (int k = 0; k < NUM_E; k++) begin
      num[k]               = {cof_i.cmag[k], {FRAC_W{1'b0}}};
      setup_d.lane[k].rem  = num[k];
      setup_d.lane[k].quo  = '0;
      setup_d.lane[k].neg  = cof_i.cneg[k] ^ cof_i.det[DET_W-1];
      setup_d.lane[k].ovf  = {{QUO_W{1'b0}}, num[k]} >= WIDE_W'({dmag, {QUO_W{1'b0}}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.en) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      setup_q <= setup_d;
    end
  end

  assign vld[QUO_W]  = valid_q;
  assign pipe[QUO_W] = setup_q;

  // most significant quotient bit first
  for (genvar b = 0; b < QUO_W; b++) begin : g_step
    m3inv_div_step #(.BIT(b)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   ('{en: ctl_i.en, valid: vld[b+1]}),
      .data_i  (pipe[b+1]),
      .valid_o (vld[b]),
      .data_o  (pipe[b])
    );
  end

  assign valid_o = vld[0];
  assign data_o  = pipe[0];

endmodule

@@ src/matrix3_inverse.sv @@
// top level: 3x3 integer matrix to exact determinant and Q16.16 inverse
//
// Input channel in_i carries one matrix of nine signed 16-bit elements per
// transfer; output channel out_o carries the nine inverse elements (Q16.16,
// saturated to 32 bits, truncated toward zero), the 49-bit determinant and
// the singular flag. A zero determinant returns the identity and singular=1.
// From input transfer to output valid a matrix passes four stages for
// products, cofactors and determinant, one setup stage, 32 restoring
// division stages (one quotient bit each), and the output register.
// Throughput is one matrix per cycle while the receiver takes results.
// The whole pipe advances together; in_i.ready is high whenever the output
// register is empty or being taken, so a stalled receiver holds every
// stage in place and nothing is dropped or repeated.
// Reset clears all valid bits; the block is ready right after reset.
module matrix3_inverse import m3inv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  m3inv_in_if.sink    in_i,
  m3inv_out_if.source out_o
);

  logic              en;
  mat_t              mat;
  logic              adj_valid;
  cof_t              cof;
  logic              div_valid;
  div_t              div;
  logic              out_valid_q;
  logic [QUO_W-1:0]  inv_q [NUM_E];
  logic [QUO_W-1:0]  inv_d [NUM_E];
  logic [DET_W-1:0]  det_q;
  logic              sing_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign mat = {in_i.a_r2c2, in_i.a_r2c1, in_i.a_r2c0, in_i.a_r1c2, in_i.a_r1c1,
                in_i.a_r1c0, in_i.a_r0c2, in_i.a_r0c1, in_i.a_r0c0};

  m3inv_adjugate u_adj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: en, valid: in_i.valid}),
    .mat_i   (mat),
    .valid_o (adj_valid),
    .cof_o   (cof)
  );

  m3inv_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: en, valid: adj_valid}),
    .cof_i   (cof),
    .valid_o (div_valid),
    .data_o  (div)
  );

  // sign, saturation and identity for a singular matrix
  always_comb begin
    for (int k = 0; k < NUM_E; k++) begin
      if (div.singular) begin
        inv_d[k] = (k % 4 == 0) ? Q_ONE : '0;
      end else if (div.lane[k].ovf) begin
        inv_d[k] = div.lane[k].neg ? SAT_NEG : SAT_POS;
      end else if (div.lane[k].neg) begin
        inv_d[k] = (div.lane[k].quo > SAT_NEG) ? SAT_NEG : -div.lane[k].quo;
      end else begin
        inv_d[k] = (div.lane[k].quo > SAT_POS) ? SAT_POS : div.lane[k].quo;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q  <= inv_d;
      det_q  <= div.singular ? '0 : div.det;
      sing_q <= div.singular;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.inv_r0c0  = inv_q[0];
  assign out_o.inv_r0c1  = inv_q[1];
  assign out_o.inv_r0c2  = inv_q[2];
  assign out_o.inv_r1c0  = inv_q[3];
  assign out_o.inv_r1c1  = inv_q[4];
  assign out_o.inv_r1c2  = inv_q[5];
  assign out_o.inv_r2c0  = inv_q[6];
  assign out_o.inv_r2c1  = inv_q[7];
  assign out_o.inv_r2c2  = inv_q[8];
  assign out_o.det_value = det_q;
  assign out_o.singular  = sing_q;

endmodule

@@ src/m3inv_chk.sv @@
// port-level checker for the matrix inverse, bound to the top level
module m3inv_chk import m3inv_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [QUO_W-1:0] inv_r0c0,
  input logic [QUO_W-1:0] inv_r0c1,
  input logic [DET_W-1:0] det_value,
  input logic             singular
);

  // a stalled result stays valid and holds its determinant and singular flag
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(det_value) && $stable(singular))
    else $error("output changed while stalled");

  // singular flag and determinant agree
  a_sing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (singular == (det_value == '0)))
    else $error("singular flag does not match determinant");

  // singular result is the identity, checked on inv_r0c0 and inv_r0c1
  a_ident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && singular |-> inv_r0c0 == Q_ONE && inv_r0c1 == '0)
    else $error("singular result is not the identity");

  // a full output register that is not taken blocks input
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

endmodule

bind matrix3_inverse m3inv_chk u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .inv_r0c0  (out_o.inv_r0c0),
  .inv_r0c1  (out_o.inv_r0c1),
  .det_value (out_o.det_value),
  .singular  (out_o.singular)
);
